[rtl/dpm_pkg.sv]
`timescale 1ns / 1ps

package dpm_pkg;

   // Field widths
   localparam int SampleW = 16;
   localparam int VolumeW = 7;
   localparam int GainW   = 7;
   localparam int PulseW  = 32;
   localparam int LevelW  = 16;

   typedef logic signed [SampleW-1:0] sample_type;
   typedef logic [VolumeW-1:0]        volume_type;
   typedef logic [GainW-1:0]          gain_type;
   typedef logic [PulseW-1:0]         pulse_type;
   typedef logic [LevelW-1:0]         level_type;

   localparam volume_type VolumeMax  = 7'd100;
   localparam logic [31:0] DitherSeed = 32'h6D2B_79F5;

   // floor(2^22 / 100); one correction step recovers the exact quotient
   localparam logic [15:0] RecipMul   = 16'd41943;
   localparam int          RecipShift = 22;

   // Displayed volume to gain: three straight segments
   function automatic gain_type map_volume(input volume_type v);
      logic [7:0]  t;
      logic [15:0] p;
      gain_type    g;
      t = '0;
      p = '0;
      if (v <= 7'd10) begin
         g = GainW'({v, 2'b00});
      end else if (v <= 7'd50) begin
         // (v-10)*30/40 == ((v-10)*3) >> 2
         t = 8'(v - 7'd10) * 8'd3;
         g = 7'd40 + GainW'(t >> 2);
      end else begin
         // (v-50)*30/50 == ((v-50)*3)/5, via *205 >> 10 (exact for t <= 150)
         t = 8'(v - 7'd50) * 8'd3;
         p = 16'(t) * 16'd205;
         g = 7'd70 + GainW'(p >> 10);
      end
      return g;
   endfunction

   // 32-bit xorshift, shifts 13 / 17 / 5
   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] d;
      d = s;
      d = d ^ (d << 13);
      d = d ^ (d >> 17);
      d = d ^ (d << 5);
      return d;
   endfunction

endpackage

[rtl/dithered_pdm_modulator.sv]
`timescale 1ns / 1ps

// Dithered first-order pulse-density modulator. Each PCM sample beat on req_
// yields one rsp_ beat of 32 pulse bits (bit 0 first in time). The sample is
// scaled by the mapped volume, divided by 100 toward zero, dithered by a
// xorshift source when nonzero, clamped and offset to an unsigned level, and
// fed to the density accumulator. The datapath is a five-register pipeline
// (input, gain multiply, reciprocal multiply, quotient correction, dither and
// clamp) plus the result register: one sample is taken every clock cycle unless
// the result channel stalls. The pulse word is built combinationally from the
// accumulator and k*level for each slot, so the only loops between samples are
// the accumulator and the dither state, each one add or xorshift per cycle.
// csr_ready is always high; write the volume only while no samples are in
// flight. Volumes above 100 read as 100.
module dithered_pdm_modulator #(
   parameter int OVERSAMPLE_RATIO = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // sample channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dpm_pkg::sample_type  req_pcm_sample,
   // pulse channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dpm_pkg::pulse_type   rsp_pulse_bits,
   // volume register
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  dpm_pkg::volume_type  csr_volume_level
);

   import dpm_pkg::*;

   localparam int RatioW = $clog2(OVERSAMPLE_RATIO + 1);
   localparam int LaneW  = LevelW + $clog2(PulseW);
   localparam int StepW  = LevelW + RatioW;

   // Configuration and loop state
   gain_type          gain_ff, gain_in;
   logic [31:0]       dither_ff, dither_in;
   level_type         acc_ff, acc_in;

   // Pipeline registers
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic              rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
   sample_type        sample_ff;
   logic              neg2_ff, neg3_ff;
   logic [21:0]       mag2_ff, mag3_ff;
   logic [15:0]       qe3_ff;
   logic signed [16:0] pcm4_ff;
   level_type         level5_ff;
   pulse_type         pulse_ff, pulse_in;

   // Stage next values
   logic signed [23:0] prod;
   logic [37:0]        recip;
   logic [21:0]        rem;
   logic [15:0]        quot;
   logic [31:0]        dither_next;
   logic signed [4:0]  dith;
   logic signed [17:0] dsum;
   level_type          level_in;
   logic [StepW-1:0]   acc_step;

   // Backpressure: a stage loads when empty or when it is moving on
   always_comb begin
      rdy_out = !rsp_valid_ff || !rsp_stall;
      rdy5    = !v5_ff || rdy_out;
      rdy4    = !v4_ff || rdy5;
      rdy3    = !v3_ff || rdy4;
      rdy2    = !v2_ff || rdy3;
      rdy1    = !v1_ff || rdy2;
   end

   assign req_stall      = !rdy1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pulse_bits = pulse_ff;
   assign csr_ready      = 1'b1;

   // Volume write: saturate, then map to gain
   always_comb begin
      gain_in = gain_ff;
      if (csr_valid) begin
         gain_in = map_volume((csr_volume_level > VolumeMax) ? VolumeMax : csr_volume_level);
      end
   end

   // Gain multiply and magnitude
   always_comb begin
      prod = sample_ff * signed'({1'b0, gain_ff});
   end

   // Quotient estimate: never more than one below the true quotient
   always_comb begin
      recip = 38'(mag2_ff) * 38'(RecipMul);
   end

   // Correction step and sign restore
   always_comb begin
      rem  = mag3_ff - 22'(qe3_ff * 22'd100);
      quot = qe3_ff + 16'(rem >= 22'd100);
   end

   // Dither, clamp, offset to unsigned level
   always_comb begin
      dither_next = xorshift32(dither_ff);
      dither_in   = dither_ff;
      dith        = signed'({1'b0, dither_next[27:24]}) - signed'({1'b0, dither_next[23:20]});
      dsum        = 18'(pcm4_ff);
      if (pcm4_ff != '0) begin
         dsum = 18'(pcm4_ff) + 18'(dith);
         if (rdy5 && v4_ff) begin
            dither_in = dither_next;
         end
      end
      if (dsum > 18'sd32767) begin
         level_in = 16'hFFFF;
      end else if (dsum < -18'sd32768) begin
         level_in = 16'h0000;
      end else begin
         level_in = dsum[15:0] ^ 16'h8000;
      end
   end

   // Pulse slots: slot k carries out of acc + k*level + level
   always_comb begin
      pulse_in = '0;
      for (int k = 0; k < PulseW; k++) begin
         logic [LaneW-1:0]  lane_mul;
         logic [LevelW-1:0] lane_sum;
         logic [LevelW:0]   lane_carry;
         lane_mul   = LaneW'(level5_ff) * LaneW'(k);
         lane_sum   = acc_ff + lane_mul[LevelW-1:0];
         lane_carry = {1'b0, lane_sum} + {1'b0, level5_ff};
         if (k < OVERSAMPLE_RATIO) begin
            pulse_in[k] = lane_carry[LevelW];
         end
      end
   end

   // Accumulator advances by ratio*level per sample
   always_comb begin
      acc_step = StepW'(level5_ff) * StepW'(OVERSAMPLE_RATIO);
      acc_in   = acc_ff;
      if (rdy_out && v5_ff) begin
         acc_in = acc_ff + acc_step[LevelW-1:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= map_volume(VolumeMax);
         dither_ff    <= DitherSeed;
         acc_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff   <= gain_in;
         dither_ff <= dither_in;
         acc_ff    <= acc_in;
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy_out) begin
            rsp_valid_ff <= v5_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (rdy1) begin
         sample_ff <= req_pcm_sample;
      end
      if (rdy2) begin
         neg2_ff <= prod[23];
         mag2_ff <= prod[23] ? 22'(-prod) : 22'(prod);
      end
      if (rdy3) begin
         neg3_ff <= neg2_ff;
         mag3_ff <= mag2_ff;
         qe3_ff  <= recip[RecipShift+15:RecipShift];
      end
      if (rdy4) begin
         pcm4_ff <= neg3_ff ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
      end
      if (rdy5) begin
         level5_ff <= level_in;
      end
      if (rdy_out) begin
         pulse_ff <= pulse_in;
      end
   end

endmodule

[rtl/dpm_checker.sv]
`timescale 1ns / 1ps

module dpm_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  dpm_pkg::pulse_type  rsp_pulse_bits
);

   import dpm_pkg::*;

   // Beats in flight: five pipeline stages plus the result register
   localparam logic [2:0] Depth = 3'd6;

   logic [2:0] inflight_ff, inflight_in;
   logic       in_beat, out_beat;

   assign in_beat  = req_valid && !req_stall;
   assign out_beat = rsp_valid && !rsp_stall;

   always_comb begin
      inflight_in = inflight_ff + 3'(in_beat) - 3'(out_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pulse_bits))
      else $error("result beat changed while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown straight after reset");

   // Every result beat stems from an accepted sample, never beyond capacity
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || inflight_ff != 3'd0) && inflight_ff <= Depth)
      else $error("result beat without a sample in flight");

   // With no result waiting nothing can hold the input back
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind dithered_pdm_modulator dpm_checker u_dpm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pulse_bits (rsp_pulse_bits)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import dpm_pkg::*;

   localparam int Ratio       = 32;
   localparam int DrainCycles = 8;     // pipeline is five deep, plus margin
   localparam int QuietLimit  = 1000;  // cycles with no beat on any channel
   localparam int PhaseCount  = 12;
   localparam int PhaseBeats  = 150;

   typedef enum bit {RowSample, RowVolume} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      bit           typed;
      pulse_type    bits;
   } plan_row_type;

   // Directed plan: extremes of sample and volume, curve knees, silent samples
   plan_row_type plan [24] = '{
      '{RowSample, 0,      1'b1, 32'hAAAA_AAAA},  // mid level from a clear accumulator
      '{RowSample, 32767,  1'b0, '0},
      '{RowSample, -32768, 1'b0, '0},
      '{RowSample, 1,      1'b0, '0},
      '{RowSample, -1,     1'b0, '0},
      '{RowVolume, 0,      1'b0, '0},
      '{RowSample, 32767,  1'b0, '0},
      '{RowSample, -32768, 1'b0, '0},
      '{RowVolume, 10,     1'b0, '0},
      '{RowSample, 32767,  1'b0, '0},
      '{RowVolume, 11,     1'b0, '0},
      '{RowSample, -32768, 1'b0, '0},
      '{RowVolume, 50,     1'b0, '0},
      '{RowSample, 12345,  1'b0, '0},
      '{RowVolume, 51,     1'b0, '0},
      '{RowSample, -12345, 1'b0, '0},
      '{RowVolume, 127,    1'b0, '0},  // saturates to full scale
      '{RowSample, 32767,  1'b0, '0},
      '{RowVolume, 101,    1'b0, '0},
      '{RowSample, 2,      1'b0, '0},
      '{RowVolume, 1,      1'b0, '0},
      '{RowSample, 24,     1'b0, '0},  // scales to zero: no dither step
      '{RowSample, -24,    1'b0, '0},
      '{RowSample, 25,     1'b0, '0}
   };

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   sample_type req_pcm_sample   = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   pulse_type  rsp_pulse_bits;
   logic       csr_valid        = 1'b0;
   logic       csr_ready;
   volume_type csr_volume_level = '0;

   // Predictor state
   int unsigned model_volume;
   logic [31:0] model_dither;
   int unsigned model_acc;

   pulse_type   pulse_q [$];
   int          fail_count   = 0;
   bit          gaps_enabled = 1'b1;
   int          stall_left   = 0;
   int          quiet_cycles = 0;

   dithered_pdm_modulator #(
      .OVERSAMPLE_RATIO (Ratio)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pcm_sample   (req_pcm_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pulse_bits   (rsp_pulse_bits),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_volume_level (csr_volume_level)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Displayed volume to gain, three segments
   function automatic int unsigned volume_gain(input int unsigned v);
      if (v <= 10) begin
         return v * 4;
      end else if (v <= 50) begin
         return 40 + ((v - 10) * 30) / 40;
      end
      return 70 + ((v - 50) * 30) / 50;
   endfunction

   // Scale, dither, clamp, then run the accumulator over the pulse slots
   function automatic pulse_type pdm_next_word(input sample_type s);
      int          scaled;
      logic [31:0] d;
      int unsigned lvl;
      pulse_type   w;
      scaled = (int'(s) * int'(volume_gain(model_volume))) / 100;
      if (scaled != 0) begin
         d = model_dither;
         d = d ^ (d << 13);
         d = d ^ (d >> 17);
         d = d ^ (d << 5);
         model_dither = d;
         scaled = scaled + int'(d[27:24]) - int'(d[23:20]);
      end
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      lvl = unsigned'(scaled + 32768);
      w = '0;
      for (int k = 0; k < Ratio; k++) begin
         model_acc = model_acc + lvl;
         if (model_acc >= 65536) begin
            model_acc = model_acc - 65536;
            if (k < PulseW) w[k] = 1'b1;
         end
      end
      return w;
   endfunction

   // Sample mix: rails, tiny values near the silent band, zero, full random
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return sample_type'(32767);
         1: return sample_type'(-32768);
         2: return sample_type'(int'($urandom_range(0, 60)) - 30);
         3: return '0;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Let every outstanding beat come back, then let the pipeline settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pulse_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_volume(input int v);
      wait_drained();
      csr_valid        <= 1'b1;
      csr_volume_level <= volume_type'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model_volume = (v > int'(VolumeMax)) ? int'(VolumeMax) : v;
   endtask

   task automatic send_sample(input sample_type s, input bit typed, input pulse_type typed_bits);
      pulse_type predicted;
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pcm_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = pdm_next_word(s);
      pulse_q.push_back(typed ? typed_bits : predicted);
   endtask

   // Result side: check each beat, then decide the stall for the next cycle
   always @(posedge clock) begin : rsp_side
      pulse_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pulse_q.size() == 0) begin
            $error("pulse_bits: no beat expected, actual %h", rsp_pulse_bits);
            fail_count++;
         end else begin
            want = pulse_q.pop_front();
            if (rsp_pulse_bits !== want) begin
               $error("pulse_bits: expected %h, actual %h", want, rsp_pulse_bits);
               fail_count++;
            end
         end
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on channel activity
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("[dithered_pdm_modulator] ERROR");
         $finish;
      end
   end

   initial begin
      int vol_pick [8];
      int vol;
      vol_pick     = '{0, 100, 127, 10, 11, 50, 51, 1};
      model_volume = int'(VolumeMax);
      model_dither = DitherSeed;
      model_acc    = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (plan[i]) begin
         if (plan[i].kind == RowVolume) begin
            write_volume(plan[i].value);
         end else begin
            send_sample(sample_type'(plan[i].value), plan[i].typed, plan[i].bits);
         end
      end

      // Random phases, each at its own volume; the last two run without gaps
      for (int p = 0; p < PhaseCount; p++) begin
         vol = (p < 8) ? vol_pick[p] : int'($urandom_range(0, 127));
         write_volume(vol);
         if (p >= PhaseCount - 2) gaps_enabled = 1'b0;
         for (int n = 0; n < PhaseBeats; n++) begin
            if (p == 3 && n == PhaseBeats / 2) wait_drained();
            send_sample(pick_sample(), 1'b0, '0);
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("[dithered_pdm_modulator] OK");
      end else begin
         $display("[dithered_pdm_modulator] ERROR");
      end
      $finish;
   end

endmodule

[dithered_pdm_modulator.f]
rtl/dpm_pkg.sv
rtl/dithered_pdm_modulator.sv
rtl/dpm_checker.sv
bench/tb_top.sv
